// ===== sv/stl_pkg.sv =====
// Shared types, codes and constants for the sorted timestamp log.
package stl_pkg;

  localparam int STAMP_W       = 64;
  localparam int REQ_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int OUT_CNT_W     = 9;
  localparam int LOG_DEPTH_DEF = 256;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MERGE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SCAN,
    CELL_APPEND,
    CELL_MERGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [STAMP_W-1:0] stamp;
  } cell_cmd_t;

endpackage

// ===== sv/stl_cell.sv =====
// One log entry cell: stored stamp, compare flags and a scan node for the top-down search.
module stl_cell #(
  parameter int IDX_W = 8,
  parameter int CNT_W = 9,
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  stl_pkg::cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]            count,
  input  logic [stl_pkg::STAMP_W-1:0] prev_stamp,
  input  logic                        prev_found,
  input  logic                        up_found,
  input  logic                        up_dup,
  input  logic [IDX_W-1:0]            up_idx,
  output logic [stl_pkg::STAMP_W-1:0] cell_stamp,
  output logic                        found,
  output logic                        dup,
  output logic [IDX_W-1:0]            hit_idx
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic occupied;
  logic le_hit;
  logic eq_hit;

  // local compare against the request stamp
  assign occupied = MY_CNT < count;
  assign le_hit   = occupied && ($signed(cell_stamp) <= $signed(cmd.stamp));
  assign eq_hit   = occupied && (cell_stamp == cmd.stamp);

  // found: some entry at or above this cell is <= stamp; dup/hit_idx belong to the highest one
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      stl_pkg::CELL_LOAD: begin
        found   <= le_hit;
        dup     <= eq_hit;
        hit_idx <= MY_IDX;
      end
      stl_pkg::CELL_SCAN: begin
        if (up_found) begin
          found   <= 1'b1;
          dup     <= up_dup;
          hit_idx <= up_idx;
        end
      end
      stl_pkg::CELL_APPEND: begin
        if (MY_CNT == count) begin
          cell_stamp <= cmd.stamp;
        end
      end
      stl_pkg::CELL_MERGE: begin
        // cells above the insert point take the lower neighbor, the insert point takes the stamp
        if (!found) begin
          cell_stamp <= prev_found ? cmd.stamp : prev_stamp;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sorted_timestamp_log_insert.sv =====
// Sorted timestamp log: a row of compare-and-shift cells with a request sequencer.
// Append, clear and unused codes go from S_CMP to S_UPD; a merge first runs the
// log-step prefix scan in S_SCAN across the cell row, which finds the newest entry
// at or below the stamp. S_UPD writes the result once the result register is free.
// One request at a time: the next is accepted only after the result is registered.
// Synchronous active-high reset empties the log and drops any pending result.
module sorted_timestamp_log_insert #(
  parameter int LOG_DEPTH = stl_pkg::LOG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [stl_pkg::REQ_W-1:0]    req_type,
  input  logic signed [stl_pkg::STAMP_W-1:0] stamp,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [stl_pkg::STATUS_W-1:0] status,
  output logic [stl_pkg::OUT_CNT_W-1:0] position,
  output logic [stl_pkg::OUT_CNT_W-1:0] entry_total,
  output logic signed [stl_pkg::STAMP_W-1:0] newest_stamp,
  output logic                         newest_valid
);

  localparam int IDX_W  = $clog2(LOG_DEPTH);
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int STEPS  = $clog2(LOG_DEPTH);
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LOG_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SCAN, S_UPD} state_t;

  state_t                        state;
  logic [STEP_W-1:0]             step;
  logic [stl_pkg::REQ_W-1:0]     req_q;
  logic [stl_pkg::STAMP_W-1:0]   stamp_q;
  logic [CNT_W-1:0]              count;
  logic [stl_pkg::STAMP_W-1:0]   newest;

  logic [stl_pkg::STAMP_W-1:0]   cell_stamp [LOG_DEPTH];
  logic                          node_found [LOG_DEPTH];
  logic                          node_dup   [LOG_DEPTH];
  logic [IDX_W-1:0]              node_idx   [LOG_DEPTH];

  stl_pkg::cell_cmd_t            cmd;
  stl_pkg::cell_op_t             upd_op;
  logic                          res_free;
  logic                          full;
  logic [CNT_W-1:0]              target;
  logic [stl_pkg::STATUS_W-1:0]  status_next;
  logic [CNT_W-1:0]              pos_next;
  logic [CNT_W-1:0]              count_next;
  logic [stl_pkg::STAMP_W-1:0]   newest_next;

  assign req_stall = (state != S_IDLE);
  assign res_free  = !res_valid || !res_stall;
  assign full      = (count >= FULL_CNT);
  assign target    = node_found[0] ? CNT_W'(CNT_W'(node_idx[0]) + CNT_W'(1)) : '0;

  // result and cell operation for the latched request
  always_comb begin
    status_next = stl_pkg::ST_OK;
    pos_next    = '0;
    count_next  = count;
    newest_next = newest;
    upd_op      = stl_pkg::CELL_HOLD;
    unique case (req_q)
      stl_pkg::REQ_APPEND: begin
        if (full) begin
          status_next = stl_pkg::ST_FULL;
        end else begin
          pos_next    = count;
          count_next  = CNT_W'(count + CNT_W'(1));
          newest_next = stamp_q;
          upd_op      = stl_pkg::CELL_APPEND;
        end
      end
      stl_pkg::REQ_MERGE: begin
        if (node_found[0] && node_dup[0]) begin
          status_next = stl_pkg::ST_DUP;
        end else if (full) begin
          status_next = stl_pkg::ST_FULL;
        end else begin
          pos_next   = target;
          count_next = CNT_W'(count + CNT_W'(1));
          if (target == count) begin
            newest_next = stamp_q;
          end
          upd_op = stl_pkg::CELL_MERGE;
        end
      end
      stl_pkg::REQ_CLEAR: begin
        count_next  = '0;
        newest_next = '0;
      end
      default: begin
      end
    endcase
  end

  // broadcast command to the cell row
  always_comb begin
    cmd.stamp = stamp_q;
    unique case (state)
      S_CMP:   cmd.op = stl_pkg::CELL_LOAD;
      S_SCAN:  cmd.op = stl_pkg::CELL_SCAN;
      S_UPD:   cmd.op = res_free ? upd_op : stl_pkg::CELL_HOLD;
      default: cmd.op = stl_pkg::CELL_HOLD;
    endcase
  end

  // cell row; scan node of each cell looks 2**step cells up
  for (genvar k = 0; k < LOG_DEPTH; k++) begin : g_cell
    logic                        up_found;
    logic                        up_dup;
    logic [IDX_W-1:0]            up_idx;
    logic                        prev_found;
    logic [stl_pkg::STAMP_W-1:0] prev_stamp;

    always_comb begin
      up_found = 1'b0;
      up_dup   = 1'b0;
      up_idx   = '0;
      for (int j = 0; j < STEPS; j++) begin
        if ((k + (1 << j) < LOG_DEPTH) && (step == STEP_W'(j))) begin
          up_found = node_found[IDX_W'((k + (1 << j) < LOG_DEPTH) ? k + (1 << j) : k)];
          up_dup   = node_dup[IDX_W'((k + (1 << j) < LOG_DEPTH) ? k + (1 << j) : k)];
          up_idx   = node_idx[IDX_W'((k + (1 << j) < LOG_DEPTH) ? k + (1 << j) : k)];
        end
      end
    end

    if (k == 0) begin : g_bottom
      assign prev_found = 1'b1;
      assign prev_stamp = stamp_q;
    end else begin : g_upper
      assign prev_found = node_found[k-1];
      assign prev_stamp = cell_stamp[k-1];
    end

    stl_cell #(
      .IDX_W(IDX_W),
      .CNT_W(CNT_W),
      .INDEX(k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .prev_stamp (prev_stamp),
      .prev_found (prev_found),
      .up_found   (up_found),
      .up_dup     (up_dup),
      .up_idx     (up_idx),
      .cell_stamp (cell_stamp[k]),
      .found      (node_found[k]),
      .dup        (node_dup[k]),
      .hit_idx    (node_idx[k])
    );
  end

  // sequencer, log state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= '0;
      newest    <= '0;
      res_valid <= 1'b0;
    end else begin
      // a result taken while a new one loads is replaced in S_UPD
      if (res_valid && !res_stall && (state != S_UPD)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q   <= req_type;
            stamp_q <= stamp;
            state   <= S_CMP;
          end
        end
        S_CMP: begin
          step  <= '0;
          state <= (req_q == stl_pkg::REQ_MERGE) ? S_SCAN : S_UPD;
        end
        S_SCAN: begin
          if (step == STEP_W'(STEPS - 1)) begin
            state <= S_UPD;
          end else begin
            step <= STEP_W'(step + STEP_W'(1));
          end
        end
        S_UPD: begin
          if (res_free) begin
            count        <= count_next;
            newest       <= newest_next;
            res_valid    <= 1'b1;
            status       <= status_next;
            position     <= stl_pkg::OUT_CNT_W'(pos_next);
            entry_total  <= stl_pkg::OUT_CNT_W'(count_next);
            newest_valid <= (count_next != '0);
            newest_stamp <= (count_next != '0) ? newest_next : '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/stl_checker.sv =====
// Port-level checks for the sorted timestamp log, bound to the top level.
module stl_checker #(
  parameter int LOG_DEPTH = stl_pkg::LOG_DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic [stl_pkg::STATUS_W-1:0]  status,
  input logic [stl_pkg::OUT_CNT_W-1:0] position,
  input logic [stl_pkg::OUT_CNT_W-1:0] entry_total,
  input logic [stl_pkg::STAMP_W-1:0]   newest_stamp,
  input logic                          newest_valid
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result keeps its status and count
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(entry_total))
    else $error("stalled result changed");

  // newest entry flag follows the count
  a_newest_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (newest_valid == (entry_total != '0)) &&
                  (newest_valid || newest_stamp == '0))
    else $error("newest entry flag does not match count");

  // a rejected request (status not OK) reports position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != stl_pkg::ST_OK |-> position == '0)
    else $error("rejected request reports a position");

  // count stays within the log depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (LOG_DEPTH > 511) || (entry_total <= LOG_DEPTH))
    else $error("entry count beyond log depth");

endmodule

bind sorted_timestamp_log_insert stl_checker #(.LOG_DEPTH(LOG_DEPTH)) u_stl_checker (.*);

// ===== test/sorted_timestamp_log_insert_tb.sv =====
// Testbench for the sorted timestamp log: directed and random requests checked against a mirror log.
`timescale 1ns / 100ps

module sorted_timestamp_log_insert_tb;

  localparam int LOG_DEPTH = stl_pkg::LOG_DEPTH_DEF;
  localparam int IDX_W = $clog2(LOG_DEPTH);
  localparam logic [stl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int STREAM_ITEMS = 200;
  localparam int RANDOM_ITEMS = 550;

  typedef struct packed {
    logic [stl_pkg::STATUS_W-1:0]     status;
    logic [stl_pkg::OUT_CNT_W-1:0]    position;
    logic [stl_pkg::OUT_CNT_W-1:0]    total;
    logic signed [stl_pkg::STAMP_W-1:0] newest;
    logic                             nvalid;
  } log_result_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               req_valid = 1'b0;
  logic                               req_stall;
  logic [stl_pkg::REQ_W-1:0]          req_type = stl_pkg::REQ_APPEND;
  logic signed [stl_pkg::STAMP_W-1:0] stamp = '0;
  logic                               res_valid;
  logic                               res_stall = 1'b0;
  logic [stl_pkg::STATUS_W-1:0]       status;
  logic [stl_pkg::OUT_CNT_W-1:0]      position;
  logic [stl_pkg::OUT_CNT_W-1:0]      entry_total;
  logic signed [stl_pkg::STAMP_W-1:0] newest_stamp;
  logic                               newest_valid;

  // mirror of the log contents
  logic signed [stl_pkg::STAMP_W-1:0] log_mirror [LOG_DEPTH];
  int                                 log_count = 0;

  log_result_t pending_results[$];
  int          err_count = 0;
  bit          idle_on = 1'b1;
  int          hold_left = 0;

  sorted_timestamp_log_insert #(.LOG_DEPTH(LOG_DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .stamp        (stamp),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .position     (position),
    .entry_total  (entry_total),
    .newest_stamp (newest_stamp),
    .newest_valid (newest_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shift younger entries up and drop the stamp into its slot
  function automatic void place_stamp(input int slot,
                                      input logic signed [stl_pkg::STAMP_W-1:0] ts);
    for (int i = log_count; i > slot; i--) log_mirror[IDX_W'(i)] = log_mirror[IDX_W'(i - 1)];
    log_mirror[IDX_W'(slot)] = ts;
    log_count++;
  endfunction

  // apply one request to the mirror log and return the result it produces
  function automatic log_result_t apply_request(input logic [stl_pkg::REQ_W-1:0] kind,
                                                input logic signed [stl_pkg::STAMP_W-1:0] ts);
    log_result_t r;
    int          i;
    int          slot;
    bit          dup;
    r = '0;
    slot = 0;
    dup = 1'b0;
    r.status = stl_pkg::ST_OK;
    case (kind)
      stl_pkg::REQ_APPEND: begin
        if (log_count >= LOG_DEPTH) r.status = stl_pkg::ST_FULL;
        else begin
          slot = log_count;
          place_stamp(slot, ts);
        end
      end
      stl_pkg::REQ_MERGE: begin
        // scan from the newest entry back to the first smaller or equal one
        i = log_count;
        while (i > 0) begin
          if (log_mirror[IDX_W'(i - 1)] < ts) begin
            slot = i;
            break;
          end
          if (log_mirror[IDX_W'(i - 1)] == ts) begin
            dup = 1'b1;
            break;
          end
          i--;
        end
        if (dup) r.status = stl_pkg::ST_DUP;
        else if (log_count >= LOG_DEPTH) begin
          r.status = stl_pkg::ST_FULL;
          slot = 0;
        end else place_stamp(slot, ts);
      end
      stl_pkg::REQ_CLEAR: log_count = 0;
      default: ;
    endcase
    r.position = slot[stl_pkg::OUT_CNT_W-1:0];
    r.total    = log_count[stl_pkg::OUT_CNT_W-1:0];
    if (log_count > 0) begin
      r.newest = log_mirror[IDX_W'(log_count - 1)];
      r.nvalid = 1'b1;
    end
    return r;
  endfunction

  // stamp mix: small values for collisions, extremes, stored values, full range
  function automatic logic signed [stl_pkg::STAMP_W-1:0] pick_stamp();
    logic signed [stl_pkg::STAMP_W-1:0] ts;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        ts = stl_pkg::STAMP_W'($urandom_range(0, 40));
        ts = ts - 64'sd20;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: ts = {1'b1, {(stl_pkg::STAMP_W-1){1'b0}}};
          1: ts = {1'b0, {(stl_pkg::STAMP_W-1){1'b1}}};
          2: ts = '0;
          default: ts = '1;
        endcase
      end
      5, 6: begin
        if (log_count > 0) ts = log_mirror[IDX_W'($urandom_range(0, log_count - 1))];
        else ts = {$urandom, $urandom};
      end
      default: ts = {$urandom, $urandom};
    endcase
    return ts;
  endfunction

  // drive one transaction and record its expected result on acceptance
  task automatic send_req(input logic [stl_pkg::REQ_W-1:0] kind,
                          input logic signed [stl_pkg::STAMP_W-1:0] ts);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    stamp     <= ts;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(apply_request(kind, ts));
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
  endtask

  // result stall: random bursts while idling is on
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 4) == 0) hold_left = $urandom_range(1, 9);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    log_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, {55'd0, entry_total});
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(status));
        if (position !== want.position)
          note_mismatch("position", 64'(want.position), 64'(position));
        if (entry_total !== want.total)
          note_mismatch("entry_total", 64'(want.total), 64'(entry_total));
        if (newest_stamp !== want.newest)
          note_mismatch("newest_stamp", want.newest, newest_stamp);
        if (newest_valid !== want.nvalid)
          note_mismatch("newest_valid", 64'(want.nvalid), 64'(newest_valid));
      end
    end
  end

  // extremes, every request code, ordering corner cases
  task automatic test_directed();
    send_req(stl_pkg::REQ_MERGE, 64'sd5);      // merge into empty log
    send_req(stl_pkg::REQ_MERGE, 64'sd3);      // below all entries
    send_req(stl_pkg::REQ_MERGE, 64'sd9);
    send_req(stl_pkg::REQ_MERGE, 64'sd7);      // middle insert with shift
    send_req(stl_pkg::REQ_MERGE, 64'sd7);      // duplicate
    send_req(stl_pkg::REQ_APPEND, -64'sd1);    // append leaves log unordered
    send_req(stl_pkg::REQ_MERGE, 64'sd6);      // stops at the appended entry
    send_req(stl_pkg::REQ_MERGE, {1'b1, {(stl_pkg::STAMP_W-1){1'b0}}});
    send_req(stl_pkg::REQ_MERGE, {1'b0, {(stl_pkg::STAMP_W-1){1'b1}}});
    send_req(stl_pkg::REQ_APPEND, {1'b1, {(stl_pkg::STAMP_W-1){1'b0}}});
    send_req(stl_pkg::REQ_APPEND, {1'b0, {(stl_pkg::STAMP_W-1){1'b1}}});
    send_req(stl_pkg::REQ_APPEND, 64'sd0);
    send_req(stl_pkg::REQ_MERGE, 64'sd0);      // duplicate of newest
    send_req(REQ_UNUSED, {$urandom, $urandom});
    send_req(stl_pkg::REQ_CLEAR, {$urandom, $urandom});
    send_req(stl_pkg::REQ_CLEAR, 64'sd0);      // clear on empty log
    send_req(REQ_UNUSED, 64'sd0);              // unused code on empty log
    send_req(stl_pkg::REQ_APPEND, 64'h5555_5555_5555_5555);
    send_req(stl_pkg::REQ_APPEND, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(stl_pkg::REQ_MERGE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(stl_pkg::REQ_MERGE, 64'h5555_5555_5555_5555);
    send_req(stl_pkg::REQ_CLEAR, '1);
  endtask

  // fill to capacity, then store and duplicate on a full log
  task automatic test_full_log();
    logic signed [stl_pkg::STAMP_W-1:0] ts;
    send_req(stl_pkg::REQ_CLEAR, 64'sd0);
    while (log_count < LOG_DEPTH) begin
      if ($urandom_range(0, 1) == 0) send_req(stl_pkg::REQ_APPEND, pick_stamp());
      else send_req(stl_pkg::REQ_MERGE, pick_stamp());
    end
    send_req(stl_pkg::REQ_APPEND, pick_stamp());
    ts = log_mirror[IDX_W'($urandom_range(0, LOG_DEPTH - 1))];
    send_req(stl_pkg::REQ_MERGE, ts);          // duplicate on a full log
    send_req(stl_pkg::REQ_MERGE, {$urandom, $urandom});
    send_req(stl_pkg::REQ_MERGE, pick_stamp());
    send_req(REQ_UNUSED, pick_stamp());
    send_req(stl_pkg::REQ_CLEAR, pick_stamp());
  endtask

  // random segments that grow the log, each ended by a clear
  task automatic test_random_mix();
    int sent;
    int seg_len;
    int roll;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      seg_len = $urandom_range(20, 300);
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) send_req(stl_pkg::REQ_MERGE, pick_stamp());
        else if (roll < 94) send_req(stl_pkg::REQ_APPEND, pick_stamp());
        else if (roll < 99) send_req(REQ_UNUSED, pick_stamp());
        else send_req(stl_pkg::REQ_CLEAR, pick_stamp());
        sent++;
      end
      send_req(stl_pkg::REQ_CLEAR, pick_stamp());
      sent++;
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_streaming();
    int roll;
    idle_on = 1'b0;
    repeat (STREAM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) send_req(stl_pkg::REQ_MERGE, pick_stamp());
      else if (roll < 90) send_req(stl_pkg::REQ_APPEND, pick_stamp());
      else if (roll < 96) send_req(REQ_UNUSED, pick_stamp());
      else send_req(stl_pkg::REQ_CLEAR, pick_stamp());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_log();
    test_random_mix();
    test_streaming();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
